// ===== rtl/core/wfts_pkg.sv =====
// ----------------------------------------------------------------------------
// wfts_pkg
// Shared widths, opcodes and types of the weighted fractal table sum block.
// ----------------------------------------------------------------------------
package wfts_pkg;

   localparam int TABLE_DEPTH = 4096;
   localparam int ADDR_W      = $clog2(TABLE_DEPTH);
   localparam int TERM_SLOTS  = 32;
   localparam int TERM_W      = $clog2(TERM_SLOTS);
   localparam int SIZE_W      = 13;
   localparam int COUNT_W     = 6;
   localparam int POS_W       = 24;
   localparam int SCALE_W     = 40;
   localparam int HALF_W      = SCALE_W / 2;
   localparam int SAMPLE_W    = 16;
   localparam int FRAC_W      = 24;
   localparam int SUM_W       = 36;
   localparam int ACC_W       = 38;

   // shared multiplier: signed operands wide enough for every unsigned use
   localparam int MUL_A_W     = POS_W + 1;
   localparam int MUL_B_W     = HALF_W + 1;
   localparam int PROD_W      = MUL_A_W + MUL_B_W;

   localparam int CSR_INDEX_W = 2;
   localparam logic [CSR_INDEX_W-1:0] CSR_TABLE_SIZE = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_TERM_COUNT = 2'd1;

   typedef enum logic [1:0] {
      OP_LOAD_SAMPLE = 2'd0,
      OP_LOAD_TERM   = 2'd1,
      OP_EVAL        = 2'd2
   } op_type;

   typedef struct packed {
      logic signed [MUL_A_W-1:0] a;
      logic signed [MUL_B_W-1:0] b;
   } mul_req_type;

   typedef logic signed [PROD_W-1:0] prod_type;

endpackage

// ===== rtl/core/wfts_mul.sv =====
// ----------------------------------------------------------------------------
// wfts_mul
// Shared signed multiplier with a registered product.
// ----------------------------------------------------------------------------
module wfts_mul (
   input  logic                  clock,
   input  wfts_pkg::mul_req_type req,
   output wfts_pkg::prod_type    prod_ff
);

   wfts_pkg::prod_type prod_in;

   assign prod_in = wfts_pkg::PROD_W'(req.a * req.b);

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

endmodule

// ===== rtl/core/weighted_fractal_table_sum.sv =====
// ----------------------------------------------------------------------------
// weighted_fractal_table_sum
// Sample table and term store with an iterative weighted table-sum evaluator.
// ----------------------------------------------------------------------------
// A load-sample or load-term beat is taken while idle and gives no result.
// An evaluate beat walks the active terms one at a time through a single
// shared multiplier (scale low half, scale high half, index scaling, weight
// times sample), and then hands the sum to the output register. The input
// is stalled after the evaluate beat until the block is idle again; N, the
// active term count, is 20 at reset, and with N of 0 the walk is skipped.
// The result sits in an output register, so load beats are taken while it
// waits; a following evaluation holds in its done state until that register
// frees up.
// Write the csr channel only while no evaluation is in flight.
// ----------------------------------------------------------------------------
module weighted_fractal_table_sum (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // slot[11:0], sample_value[27:12], term_weight_in[43:28],
   // term_scale_in[83:44], position[107:84], zero pad[111:108]
   input  logic [111:0] req_tdata,
   // opcode[1:0]
   input  logic [1:0]   req_tuser,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // sum_value[35:0], zero pad[39:36]
   output logic [39:0]  rsp_tdata,
   input  logic         csr_valid,
   output logic         csr_ready,
   input  logic [1:0]   csr_index,
   input  logic [12:0]  csr_data
);

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_FETCH,
      ST_MUL_LO,
      ST_MUL_HI,
      ST_FRAC,
      ST_IDX,
      ST_CLAMP,
      ST_SREAD,
      ST_MAC,
      ST_ACC,
      ST_DONE
   } state_type;

   localparam int TERM_ENTRY_W = wfts_pkg::SCALE_W + wfts_pkg::SAMPLE_W;
   localparam int IDX_PROD_W   = wfts_pkg::FRAC_W + wfts_pkg::SIZE_W;
   localparam logic [IDX_PROD_W-1:0] ROUND_HALF =
      IDX_PROD_W'(1) << (wfts_pkg::FRAC_W - 1);
   localparam logic [wfts_pkg::SIZE_W-1:0] SIZE_MIN = wfts_pkg::SIZE_W'(2);
   localparam logic [wfts_pkg::SIZE_W-1:0] SIZE_MAX =
      wfts_pkg::SIZE_W'(wfts_pkg::TABLE_DEPTH);
   localparam logic [wfts_pkg::COUNT_W-1:0] TERMS_MAX =
      wfts_pkg::COUNT_W'(wfts_pkg::TERM_SLOTS);
   localparam logic signed [wfts_pkg::ACC_W-1:0] SUM_HI =
      wfts_pkg::ACC_W'((64'sd1 <<< (wfts_pkg::SUM_W - 1)) - 64'sd1);
   localparam logic signed [wfts_pkg::ACC_W-1:0] SUM_LO =
      wfts_pkg::ACC_W'(-(64'sd1 <<< (wfts_pkg::SUM_W - 1)));

   // input fields
   wfts_pkg::op_type                     opcode;
   logic [11:0]                          slot;
   logic signed [wfts_pkg::SAMPLE_W-1:0] sample_value;
   logic signed [wfts_pkg::SAMPLE_W-1:0] term_weight_in;
   logic [wfts_pkg::SCALE_W-1:0]         term_scale_in;
   logic [wfts_pkg::POS_W-1:0]           position;

   assign opcode         = wfts_pkg::op_type'(req_tuser);
   assign slot           = req_tdata[11:0];
   assign sample_value   = req_tdata[27:12];
   assign term_weight_in = req_tdata[43:28];
   assign term_scale_in  = req_tdata[83:44];
   assign position       = req_tdata[107:84];

   // registers
   state_type                             state_ff;
   logic [wfts_pkg::SIZE_W-1:0]           table_size_ff;
   logic [wfts_pkg::COUNT_W-1:0]          term_count_ff;
   logic [wfts_pkg::COUNT_W-1:0]          term_ff;
   logic [wfts_pkg::COUNT_W-1:0]          terms_ff;
   logic [wfts_pkg::SIZE_W-1:0]           size_ff;
   logic [wfts_pkg::POS_W-1:0]            pos_ff;
   logic [wfts_pkg::SCALE_W-1:0]          lo_ff;
   logic [wfts_pkg::FRAC_W-1:0]           frac_ff;
   logic [wfts_pkg::ADDR_W-1:0]           idx_ff;
   logic signed [wfts_pkg::ACC_W-1:0]     acc_ff;
   logic                                  rsp_valid_ff;
   logic [wfts_pkg::SUM_W-1:0]            rsp_data_ff;
   logic [TERM_ENTRY_W-1:0]               term_rd_ff;
   logic signed [wfts_pkg::SAMPLE_W-1:0]  sample_rd_ff;

   // memories
   logic signed [wfts_pkg::SAMPLE_W-1:0] sample_mem [wfts_pkg::TABLE_DEPTH];
   logic [TERM_ENTRY_W-1:0]              term_mem   [wfts_pkg::TERM_SLOTS];

   // datapath
   wfts_pkg::mul_req_type                mul_req;
   wfts_pkg::prod_type                   prod_ff;
   logic                                 req_beat;
   logic                                 rsp_free;
   logic [wfts_pkg::SIZE_W-1:0]          eff_size;
   logic [wfts_pkg::COUNT_W-1:0]         eff_terms;
   logic [wfts_pkg::SCALE_W-1:0]         scale_rd;
   logic signed [wfts_pkg::SAMPLE_W-1:0] weight_rd;
   logic [wfts_pkg::SCALE_W-1:0]         frac_sum;
   logic [IDX_PROD_W-1:0]                idx_round;
   logic [wfts_pkg::SIZE_W-1:0]          idx_full;
   logic [wfts_pkg::SIZE_W-1:0]          idx_last;
   logic [wfts_pkg::COUNT_W-1:0]         term_next;
   logic signed [wfts_pkg::ACC_W-1:0]    acc_sum;
   logic [wfts_pkg::SUM_W-1:0]           sum_sat;

   assign req_tready = (state_ff == ST_IDLE);
   assign req_beat   = req_tvalid && req_tready;
   assign rsp_free   = !rsp_valid_ff || rsp_tready;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {4'b0, rsp_data_ff};
   assign csr_ready  = 1'b1;

   always_comb begin
      eff_size = table_size_ff;
      if (table_size_ff < SIZE_MIN) begin
         eff_size = SIZE_MIN;
      end else if (table_size_ff > SIZE_MAX) begin
         eff_size = SIZE_MAX;
      end
      eff_terms = (term_count_ff > TERMS_MAX) ? TERMS_MAX : term_count_ff;
   end

   assign scale_rd  = term_rd_ff[TERM_ENTRY_W-1:wfts_pkg::SAMPLE_W];
   assign weight_rd = term_rd_ff[wfts_pkg::SAMPLE_W-1:0];

   // fraction of x*scale: bits 39:16 of the low partial plus the shifted high one
   assign frac_sum  = lo_ff + {prod_ff[wfts_pkg::HALF_W-1:0], {wfts_pkg::HALF_W{1'b0}}};
   assign idx_round = prod_ff[IDX_PROD_W-1:0] + ROUND_HALF;
   assign idx_full  = idx_round[IDX_PROD_W-1:wfts_pkg::FRAC_W];
   assign idx_last  = size_ff - wfts_pkg::SIZE_W'(1);
   assign term_next = term_ff + wfts_pkg::COUNT_W'(1);
   assign acc_sum   = acc_ff + prod_ff[wfts_pkg::ACC_W-1:0];

   always_comb begin
      if (acc_ff > SUM_HI) begin
         sum_sat = SUM_HI[wfts_pkg::SUM_W-1:0];
      end else if (acc_ff < SUM_LO) begin
         sum_sat = SUM_LO[wfts_pkg::SUM_W-1:0];
      end else begin
         sum_sat = acc_ff[wfts_pkg::SUM_W-1:0];
      end
   end

   // operand select for the shared multiplier
   always_comb begin
      mul_req = '0;
      case (state_ff)
         ST_MUL_LO: begin
            mul_req.a = {1'b0, pos_ff};
            mul_req.b = {1'b0, scale_rd[wfts_pkg::HALF_W-1:0]};
         end
         ST_MUL_HI: begin
            mul_req.a = {1'b0, pos_ff};
            mul_req.b = {1'b0, scale_rd[wfts_pkg::SCALE_W-1:wfts_pkg::HALF_W]};
         end
         ST_IDX: begin
            mul_req.a = {1'b0, frac_ff};
            mul_req.b = {{(wfts_pkg::MUL_B_W - wfts_pkg::SIZE_W){1'b0}}, size_ff};
         end
         ST_MAC: begin
            mul_req.a = wfts_pkg::MUL_A_W'(weight_rd);
            mul_req.b = wfts_pkg::MUL_B_W'(sample_rd_ff);
         end
         default: begin
            mul_req = '0;
         end
      endcase
   end

   wfts_mul u_mul (
      .clock   (clock),
      .req     (mul_req),
      .prod_ff (prod_ff)
   );

   always_ff @(posedge clock) begin
      if (req_beat && opcode == wfts_pkg::OP_LOAD_SAMPLE) begin
         sample_mem[slot] <= sample_value;
      end
      sample_rd_ff <= sample_mem[idx_ff];
   end

   always_ff @(posedge clock) begin
      if (req_beat && opcode == wfts_pkg::OP_LOAD_TERM &&
          slot[11:wfts_pkg::TERM_W] == '0) begin
         term_mem[slot[wfts_pkg::TERM_W-1:0]] <= {term_scale_in, term_weight_in};
      end
      term_rd_ff <= term_mem[term_ff[wfts_pkg::TERM_W-1:0]];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         table_size_ff <= SIZE_MAX;
         term_count_ff <= wfts_pkg::COUNT_W'(20);
         term_ff       <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               wfts_pkg::CSR_TABLE_SIZE: table_size_ff <= csr_data;
               wfts_pkg::CSR_TERM_COUNT: term_count_ff <= csr_data[wfts_pkg::COUNT_W-1:0];
               default: ;
            endcase
         end

         // load a finished sum, else drop the beat once it is taken
         if (state_ff == ST_DONE && rsp_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_valid_ff && rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end

         case (state_ff)
            ST_IDLE: begin
               if (req_beat && opcode == wfts_pkg::OP_EVAL) begin
                  pos_ff   <= position;
                  size_ff  <= eff_size;
                  terms_ff <= eff_terms;
                  term_ff  <= '0;
                  acc_ff   <= '0;
                  state_ff <= (eff_terms == '0) ? ST_DONE : ST_FETCH;
               end
            end
            ST_FETCH:  state_ff <= ST_MUL_LO;
            ST_MUL_LO: state_ff <= ST_MUL_HI;
            ST_MUL_HI: begin
               lo_ff    <= prod_ff[wfts_pkg::SCALE_W-1:0];
               state_ff <= ST_FRAC;
            end
            ST_FRAC: begin
               frac_ff  <= frac_sum[wfts_pkg::SCALE_W-1:wfts_pkg::SCALE_W-wfts_pkg::FRAC_W];
               state_ff <= ST_IDX;
            end
            ST_IDX: state_ff <= ST_CLAMP;
            ST_CLAMP: begin
               // clamp the rounded index to the last sample in use
               idx_ff   <= (idx_full > idx_last) ? idx_last[wfts_pkg::ADDR_W-1:0]
                                                 : idx_full[wfts_pkg::ADDR_W-1:0];
               state_ff <= ST_SREAD;
            end
            ST_SREAD: state_ff <= ST_MAC;
            ST_MAC:   state_ff <= ST_ACC;
            ST_ACC: begin
               acc_ff   <= acc_sum;
               term_ff  <= term_next;
               state_ff <= (term_next == terms_ff) ? ST_DONE : ST_FETCH;
            end
            ST_DONE: begin
               // hold until the output register frees up
               if (rsp_free) begin
                  rsp_data_ff  <= sum_sat;
                  state_ff     <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

endmodule

// ===== rtl/core/wfts_check.sv =====
// ----------------------------------------------------------------------------
// wfts_check
// Port-level checks of the weighted fractal table sum block.
// ----------------------------------------------------------------------------
module wfts_check (
   input logic         clock,
   input logic         reset,
   input logic         req_tvalid,
   input logic         req_tready,
   input logic [111:0] req_tdata,
   input logic [1:0]   req_tuser,
   input logic         rsp_tvalid,
   input logic         rsp_tready,
   input logic [39:0]  rsp_tdata,
   input logic         csr_valid,
   input logic         csr_ready,
   input logic [1:0]   csr_index,
   input logic [12:0]  csr_data
);

   // a stalled result beat stays up
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid)
      else $error("result beat dropped while stalled");

   // an evaluate beat keeps the input stalled on the next cycle
   assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && req_tuser == wfts_pkg::OP_EVAL |=> !req_tready)
      else $error("input ready right after an evaluate beat");

   // a result cannot appear in the cycle right after an evaluate beat
   assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && req_tuser == wfts_pkg::OP_EVAL && !rsp_tvalid
      |=> !rsp_tvalid)
      else $error("result appeared too early");

   // pad bits above the sum stay clear
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[39:36] == 4'b0)
      else $error("result pad bits set");

endmodule

bind weighted_fractal_table_sum wfts_check u_check (.*);
